// ----- hdl/pma_pkg.sv -----
// Package with shared types and constants of the particle mover.
`default_nettype none
package pma_pkg;
    localparam int unsigned QW = 32;
    localparam logic [1:0] CMD_FORCE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;
    localparam logic [1:0] REG_MASS  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_EDGE  = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [63:0] DIST_LOW  = 64'd655360;
    localparam logic [63:0] DIST_HIGH = 64'd1638400;

    typedef struct packed {
        logic [1:0]  command;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic [15:0] other_mass;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pull_x;
        logic signed [31:0] pull_y;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_item_t;

    // Control between the sequencer and the divide/root unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [63:0] den;
    } dv_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } dv_rsp_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        if (v > mx) return 32'sh7fffffff;
        if (v < mn) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- hdl/pma_if.sv -----
// Valid/ready stream interfaces for items and configuration writes.
`default_nettype none
interface pma_in_if;
    logic valid;
    logic ready;
    pma_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pma_out_if;
    logic valid;
    logic ready;
    pma_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pma_cfg_if;
    logic valid;
    logic ready;
    pma_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/pma_divsqrt.sv -----
// Shared iterative unit: 64-bit restoring divide or integer square root.
`default_nettype none
module pma_divsqrt (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pma_pkg::dv_req_t req,
    output pma_pkg::dv_rsp_t     rsp
);
    logic        busy_reg;
    logic        sqrt_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [63:0] num_reg;
    logic [63:0] rem_next;
    logic [63:0] quo_next;
    logic [63:0] num_next;
    logic [64:0] trial;

    // One quotient bit or one root bit per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        num_next = num_reg;
        trial    = '0;
        if (sqrt_reg)
        begin
            rem_next = {rem_reg[61:0], num_reg[63:62]};
            num_next = {num_reg[61:0], 2'b00};
            trial = {1'b0, rem_next} - {1'b0, quo_reg[61:0], 2'b01};
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
        else
        begin
            trial = {rem_reg, num_reg[63]} - {1'b0, den_reg};
            num_next = {num_reg[62:0], 1'b0};
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], num_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rsp.done <= 1'b0;
            cnt_reg  <= '0;
            sqrt_reg <= 1'b0;
        end
        else
        begin
            rsp.done <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= req.is_sqrt;
                cnt_reg  <= req.is_sqrt ? 7'd32 : 7'd64;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                num_reg <= num_next;
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg   <= 1'b0;
                    rsp.done   <= 1'b1;
                    rsp.result <= quo_next;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/particle_mover_with_attraction.sv -----
// Top level: body state, command sequencer and shared divide/root unit.
//
// Input beats arrive on in_ch, result beats leave on out_ch, and
// configuration writes (mass, gain, edge limit) come on cfg_ch.
// Every input beat gives exactly one result beat with the state after the
// command. The block takes one command at a time and drops ready until
// the result has been taken.
// Apply force runs two 64-step divides on the shared unit. Tick runs
// without the unit. Attraction runs one 32-step square
// root, one strength divide and two unit divides, unless the bodies coincide.
// The shared serial divide/root unit paces force and attraction.
// The result sits in an output register; when the receiver stalls the
// block holds it and accepts nothing new.
// Reset clears the position, velocity and acceleration to zero and puts
// the registers at mass 1.0, gain about 0.4 and edge limit 256.
// Configuration writes are always ready and take effect at once.
`default_nettype none
module particle_mover_with_attraction (
    input wire logic clk,
    input wire logic rst_n,
    pma_in_if.sink   in_ch,
    pma_out_if.source out_ch,
    pma_cfg_if.sink  cfg_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_FX, S_FY, S_TICK1, S_TICK2, S_TICK3,
        S_SQRT, S_STR, S_UX, S_UY, S_PULL, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg;
    logic signed [31:0] pullx_reg, pully_reg;
    logic [15:0] mass_reg, gain_reg;
    logic [14:0] edge_reg;
    pma_pkg::in_item_t it_reg;
    logic        wait_reg;
    logic        nx_reg, ny_reg;
    logic [32:0] ax_abs_reg, ay_abs_reg;
    logic [63:0] mag_reg, str_reg, ux_reg;
    logic [47:0] prod_reg;
    logic        fneg_reg;
    pma_pkg::dv_req_t req;
    pma_pkg::dv_rsp_t rsp;

    pma_divsqrt u_dv (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    logic [15:0] meff;
    logic signed [63:0] dxs, dys;
    logic [63:0] sxx, syy, dc, den;
    logic        shf;
    logic signed [63:0] lim;
    logic [63:0] fmag;
    assign meff = (mass_reg == 16'd0) ? 16'd1 : mass_reg;
    assign lim  = {33'd0, edge_reg, 16'd0};
    assign dxs  = 64'(px_reg) - 64'(it_reg.other_x);
    assign dys  = 64'(py_reg) - 64'(it_reg.other_y);
    assign shf  = ax_abs_reg[32] | ax_abs_reg[31] | ay_abs_reg[32] | ay_abs_reg[31];
    assign sxx  = shf ? {32'd0, ax_abs_reg[32:1]} : {31'd0, ax_abs_reg};
    assign syy  = shf ? {32'd0, ay_abs_reg[32:1]} : {31'd0, ay_abs_reg};
    assign dc   = (mag_reg < pma_pkg::DIST_LOW) ? pma_pkg::DIST_LOW :
                  (mag_reg > pma_pkg::DIST_HIGH) ? pma_pkg::DIST_HIGH : mag_reg;
    assign den  = (dc[31:0] * dc[31:0]) >> 16;
    assign fmag = (ux_reg[31:0] * str_reg[31:0]) >> 16;

    logic signed [63:0] fin;
    logic signed [63:0] fq;
    logic signed [31:0] nvx, nvy, npx, npy;
    always_comb
    begin
        fin = (state_reg == S_FX) ? 64'(it_reg.force_x) : 64'(it_reg.force_y);
        fq  = fneg_reg ? -$signed(rsp.result) : $signed(rsp.result);
        nvx = pma_pkg::sat32(64'(vx_reg) + 64'(ax_reg));
        nvy = pma_pkg::sat32(64'(vy_reg) + 64'(ay_reg));
        npx = pma_pkg::sat32(64'(px_reg) + 64'(vx_reg));
        npy = pma_pkg::sat32(64'(py_reg) + 64'(vy_reg));
    end

    logic [63:0] sq_sum;
    assign sq_sum = (sxx[31:0] * sxx[31:0]) + (syy[31:0] * syy[31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            px_reg <= '0; py_reg <= '0; vx_reg <= '0; vy_reg <= '0;
            ax_reg <= '0; ay_reg <= '0;
            mass_reg <= 16'd256; gain_reg <= 16'd26214; edge_reg <= 15'd256;
            out_ch.valid <= 1'b0;
            wait_reg <= 1'b0;
            fneg_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.data.index)
                    pma_pkg::REG_MASS: mass_reg <= cfg_ch.data.data;
                    pma_pkg::REG_GAIN: gain_reg <= cfg_ch.data.data;
                    pma_pkg::REG_EDGE: edge_reg <= cfg_ch.data.data[14:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    wait_reg <= 1'b0;
                    if (in_ch.valid)
                    begin
                        it_reg <= in_ch.data;
                        pullx_reg <= '0;
                        pully_reg <= '0;
                        unique case (in_ch.data.command)
                            pma_pkg::CMD_FORCE: state_reg <= S_FX;
                            pma_pkg::CMD_TICK:  state_reg <= S_TICK1;
                            pma_pkg::CMD_PULL:  state_reg <= S_SQRT;
                            default:            state_reg <= S_OUT;
                        endcase
                    end
                end
                S_FX, S_FY:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                        fneg_reg <= fin[63];
                    end
                    else if (rsp.done)
                    begin
                        wait_reg <= 1'b0;
                        if (state_reg == S_FX)
                        begin
                            ax_reg <= pma_pkg::sat32(64'(ax_reg) + 64'(pma_pkg::sat32(fq)));
                            state_reg <= S_FY;
                        end
                        else
                        begin
                            ay_reg <= pma_pkg::sat32(64'(ay_reg) + 64'(pma_pkg::sat32(fq)));
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_TICK1:
                begin
                    vx_reg <= nvx; vy_reg <= nvy;
                    state_reg <= S_TICK2;
                end
                S_TICK2:
                begin
                    px_reg <= npx; py_reg <= npy;
                    ax_reg <= '0; ay_reg <= '0;
                    state_reg <= S_TICK3;
                end
                S_TICK3:
                begin
                    if (64'(px_reg) < -lim)
                    begin
                        px_reg <= 32'(-lim); vx_reg <= pma_pkg::sat32(-64'(vx_reg));
                    end
                    else if (64'(px_reg) > lim)
                    begin
                        px_reg <= 32'(lim); vx_reg <= pma_pkg::sat32(-64'(vx_reg));
                    end
                    if (64'(py_reg) < -lim)
                    begin
                        py_reg <= 32'(-lim); vy_reg <= pma_pkg::sat32(-64'(vy_reg));
                    end
                    else if (64'(py_reg) > lim)
                    begin
                        py_reg <= 32'(lim); vy_reg <= pma_pkg::sat32(-64'(vy_reg));
                    end
                    state_reg <= S_OUT;
                end
                S_SQRT:
                begin
                    if (!wait_reg)
                    begin
                        nx_reg <= dxs[63];
                        ny_reg <= dys[63];
                        ax_abs_reg <= dxs[63] ? 33'(-dxs) : dxs[32:0];
                        ay_abs_reg <= dys[63] ? 33'(-dys) : dys[32:0];
                        prod_reg <= 48'(gain_reg) * 48'(mass_reg);
                        wait_reg <= 1'b1;
                    end
                    else if (!fneg_reg)
                    begin
                        fneg_reg <= 1'b1;
                        if (ax_abs_reg == '0 && ay_abs_reg == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else if (rsp.done)
                    begin
                        mag_reg <= shf ? {rsp.result[62:0], 1'b0} : rsp.result;
                        prod_reg <= 48'(prod_reg[31:0]) * 48'(it_reg.other_mass);
                        wait_reg <= 1'b0;
                        fneg_reg <= 1'b0;
                        state_reg <= S_STR;
                    end
                end
                S_STR, S_UX, S_UY:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (rsp.done)
                    begin
                        wait_reg <= 1'b0;
                        unique case (state_reg)
                            S_STR: begin str_reg <= rsp.result; state_reg <= S_UX; end
                            S_UX:  begin ux_reg <= rsp.result; state_reg <= S_UY; end
                            default:
                            begin
                                ux_reg <= rsp.result;
                                pullx_reg <= pma_pkg::sat32(nx_reg ? -$signed(fmag) : $signed(fmag));
                                state_reg <= S_PULL;
                            end
                        endcase
                    end
                end
                S_PULL:
                begin
                    pully_reg <= pma_pkg::sat32(ny_reg ? -$signed(fmag) : $signed(fmag));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    wait_reg <= 1'b0;
                    fneg_reg <= 1'b0;
                    if (!out_ch.valid)
                    begin
                        out_ch.valid <= 1'b1;
                        out_ch.data <= '{px_reg, py_reg, vx_reg, vy_reg, pullx_reg, pully_reg};
                    end
                    else if (out_ch.ready)
                    begin
                        out_ch.valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Unit start requests, a one-cycle pulse sampled by the unit.
    logic        launch;
    logic        lsq;
    logic [63:0] lnum, lden;
    always_comb
    begin
        launch = 1'b0; lsq = 1'b0; lnum = '0; lden = '0;
        unique case (state_reg)
            S_FX, S_FY:
            begin
                launch = !wait_reg;
                lnum = (fin[63] ? 64'(-fin) : fin) << 8;
                lden = {48'd0, meff};
            end
            S_SQRT:
            begin
                launch = wait_reg && !fneg_reg && !(ax_abs_reg == '0 && ay_abs_reg == '0);
                lsq = 1'b1;
                lnum = sq_sum;
            end
            S_STR:
            begin
                launch = !wait_reg;
                lnum = {16'd0, prod_reg};
                lden = den;
            end
            S_UX:
            begin
                launch = !wait_reg;
                lnum = {15'd0, ax_abs_reg, 16'd0};
                lden = mag_reg;
            end
            S_UY:
            begin
                launch = !wait_reg;
                lnum = {15'd0, ay_abs_reg, 16'd0};
                lden = mag_reg;
            end
            default: ;
        endcase
    end
    assign req = '{launch, lsq, lnum, lden};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> !req.start) else $error("double launch");
endmodule
`default_nettype wire
